/* hw/rtl/fsc_pkg.sv */
// Shared types and constants of the floppy sector controller.
`default_nettype none

package fsc_pkg;

    // Operation codes carried in the command transaction.
    typedef enum logic [2:0] {
        OP_STEP        = 3'd0,
        OP_SECTOR      = 3'd1,
        OP_START_READ  = 3'd2,
        OP_START_WRITE = 3'd3,
        OP_READ_BYTE   = 3'd4,
        OP_WRITE_BYTE  = 3'd5
    } op_t;

    // Header check result reported on a write byte.
    typedef enum logic [1:0] {
        WST_OK       = 2'd0,
        WST_PREAMBLE = 2'd1,
        WST_SYNC1    = 2'd2,
        WST_SYNC2    = 2'd3
    } wr_status_t;

    // Transfer phase within the sector header.
    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    localparam logic [7:0] SYNC1_BYTE   = 8'hFB;
    localparam logic [5:0] PREAMBLE_LEN = 6'd33;
    localparam int         TRACK_W      = 6;
    localparam int         SECTOR_W     = 4;
    localparam int         SECTOR_SLOTS = 16;

    typedef struct packed {
        logic [2:0]          operation;
        logic                drive_select;
        logic                side_select;
        logic                step_outward;
        logic [7:0]          write_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0]          read_byte;
        logic [SECTOR_W-1:0] sector_number;
        logic                head_home;
        logic [1:0]          write_status;
        logic                block_done;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/fsc_cmd_if.sv */
// Command channel interface of the floppy sector controller.
`default_nettype none

interface fsc_cmd_if import fsc_pkg::*;;
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fsc_res_if.sv */
// Result channel interface of the floppy sector controller.
`default_nettype none

interface fsc_res_if import fsc_pkg::*;;
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/floppy_sector_controller.sv */
// Top level of the hard-sectored floppy controller for two drives.
`default_nettype none

// The controller takes one command transaction per clock cycle while the receiver keeps
// taking results, and returns exactly one result transaction per command, in order. At
// the accepting edge the command updates the head, sector and transfer state and issues
// at most one access to the disk memory; its result enters stage A at that same edge, as
// the memory's registered read port captures the byte, and then moves on into the output
// register. The memory port is the only shared resource, used at most once per command,
// and it serves one access per cycle, so the sustained rate is one transaction per cycle
// while results are taken. Two results can be held inside (one in stage A, one in the
// output register), so one more command is taken while a result waits. The disk memory holds
// 4*TRACKS*16*BLOCK_BYTES bytes (two drives, two sides) and is not cleared at reset:
// a byte that was never written reads back as an unknown value. The byte address is
// (((drive*2 + side)*TRACKS + track)*16 + sector)*BLOCK_BYTES + byte index, computed from
// the state left by the previous command, so a drive or side change in the middle of a
// transfer takes effect at once.
module floppy_sector_controller import fsc_pkg::*; #(
    parameter int TRACKS      = 35,
    parameter int SECTORS     = 10,
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fsc_cmd_if.sink   cmd,
    fsc_res_if.source result
);

    localparam int SIDE_BYTES  = TRACKS * SECTOR_SLOTS * BLOCK_BYTES;
    localparam int TRACK_BYTES = SECTOR_SLOTS * BLOCK_BYTES;
    localparam int MEM_DEPTH   = 4 * SIDE_BYTES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int BI_W        = $clog2(BLOCK_BYTES + 1);

    localparam logic [TRACK_W-1:0]  TRACK_MAX  = TRACK_W'(TRACKS - 1);
    localparam logic [SECTOR_W-1:0] SECTOR_MAX = SECTOR_W'(SECTORS - 1);
    localparam logic [BI_W-1:0]     BLOCK_END  = BI_W'(BLOCK_BYTES);

    // Per-drive head state and the single transfer state.
    logic [TRACK_W-1:0]  head_track_reg  [2];
    logic [TRACK_W-1:0]  head_track_next [2];
    logic [SECTOR_W-1:0] head_sector_reg  [2];
    logic [SECTOR_W-1:0] head_sector_next [2];
    logic [5:0]          preamble_count_reg, preamble_count_next;
    phase_t              sync_phase_reg, sync_phase_next;
    logic [BI_W-1:0]     byte_index_reg, byte_index_next;
    logic                reading_reg, reading_next;
    logic                writing_reg, writing_next;
    logic                head_home_reg, head_home_next;

    // Pipeline: stage A holds the result beside the registered memory byte, then the output register.
    logic                a_valid_reg;
    res_t                a_res_reg;
    logic                a_use_mem_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic [7:0]          rd_data_reg;

    logic [7:0]          disk_mem [MEM_DEPTH];

    cmd_t                c;
    logic                accept;
    logic                a_adv;
    logic [TRACK_W-1:0]  track_cur, track_new;
    logic [SECTOR_W-1:0] sector_cur;
    logic [7:0]          sync2;
    logic [ADDR_W-1:0]   mem_addr;
    logic                use_mem, store_byte;
    logic                mem_re, mem_we;
    res_t                res_now;
    res_t                a_res_final;

    assign c      = cmd.payload;
    assign a_adv  = a_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !a_valid_reg || a_adv;
    assign accept = cmd.valid && cmd.ready;

    assign track_cur  = head_track_reg[c.drive_select];
    assign sector_cur = head_sector_reg[c.drive_select];
    // The sync2 header byte carries the low track nibble above the sector number.
    assign sync2      = {track_cur[3:0], sector_cur};

    // The address terms are independent constant multiplies that meet in one adder.
    assign mem_addr = ADDR_W'({c.drive_select, c.side_select}) * ADDR_W'(SIDE_BYTES)
                    + ADDR_W'(track_cur) * ADDR_W'(TRACK_BYTES)
                    + ADDR_W'(sector_cur) * ADDR_W'(BLOCK_BYTES)
                    + ADDR_W'(byte_index_reg);

    always_comb
    begin
        head_track_next     = head_track_reg;
        head_sector_next    = head_sector_reg;
        preamble_count_next = preamble_count_reg;
        sync_phase_next     = sync_phase_reg;
        byte_index_next     = byte_index_reg;
        reading_next        = reading_reg;
        writing_next        = writing_reg;
        head_home_next      = head_home_reg;
        track_new           = track_cur;
        use_mem             = 1'b0;
        store_byte          = 1'b0;
        res_now             = '0;

        unique case (c.operation)
            OP_STEP:
            begin
                if (c.step_outward)
                begin
                    if (track_cur < TRACK_MAX)
                    begin
                        track_new = track_cur + TRACK_W'(1);
                    end
                end
                else if (track_cur != '0)
                begin
                    track_new = track_cur - TRACK_W'(1);
                end
                head_track_next[c.drive_select] = track_new;
                head_home_next = (track_new == '0);
            end
            OP_SECTOR:
            begin
                res_now.sector_number = sector_cur;
                head_sector_next[c.drive_select] =
                    (sector_cur == SECTOR_MAX) ? '0 : sector_cur + SECTOR_W'(1);
                preamble_count_next = '0;
                sync_phase_next     = PH_SYNC1;
                byte_index_next     = '0;
                reading_next        = 1'b0;
                writing_next        = 1'b0;
            end
            OP_START_READ:
            begin
                res_now.read_byte   = SYNC1_BYTE;
                preamble_count_next = '0;
                sync_phase_next     = PH_SYNC2;
                byte_index_next     = '0;
                reading_next        = 1'b1;
                writing_next        = 1'b0;
            end
            OP_START_WRITE:
            begin
                preamble_count_next = '0;
                sync_phase_next     = PH_SYNC1;
                byte_index_next     = '0;
                reading_next        = 1'b0;
                writing_next        = 1'b1;
            end
            OP_READ_BYTE:
            begin
                if (reading_reg)
                begin
                    if (sync_phase_reg == PH_SYNC2)
                    begin
                        sync_phase_next   = PH_DATA;
                        res_now.read_byte = sync2;
                    end
                    else if (byte_index_reg >= BLOCK_END)
                    begin
                        // The slot after the last data byte ends the transfer.
                        preamble_count_next = '0;
                        sync_phase_next     = PH_SYNC1;
                        byte_index_next     = '0;
                        reading_next        = 1'b0;
                        writing_next        = 1'b0;
                        res_now.block_done  = 1'b1;
                    end
                    else
                    begin
                        use_mem         = 1'b1;
                        byte_index_next = byte_index_reg + BI_W'(1);
                    end
                end
            end
            OP_WRITE_BYTE:
            begin
                if (writing_reg)
                begin
                    if (preamble_count_reg < PREAMBLE_LEN)
                    begin
                        if (c.write_byte != 8'h00)
                        begin
                            res_now.write_status = WST_PREAMBLE;
                        end
                        preamble_count_next = preamble_count_reg + 6'd1;
                    end
                    else if (sync_phase_reg == PH_SYNC1)
                    begin
                        if (c.write_byte != SYNC1_BYTE)
                        begin
                            res_now.write_status = WST_SYNC1;
                        end
                        sync_phase_next = PH_SYNC2;
                    end
                    else if (sync_phase_reg == PH_SYNC2)
                    begin
                        if (c.write_byte != sync2)
                        begin
                            res_now.write_status = WST_SYNC2;
                        end
                        sync_phase_next = PH_DATA;
                    end
                    else if (byte_index_reg >= BLOCK_END)
                    begin
                        preamble_count_next = '0;
                        sync_phase_next     = PH_SYNC1;
                        byte_index_next     = '0;
                        reading_next        = 1'b0;
                        writing_next        = 1'b0;
                        res_now.block_done  = 1'b1;
                    end
                    else
                    begin
                        store_byte      = 1'b1;
                        byte_index_next = byte_index_reg + BI_W'(1);
                    end
                end
            end
            default:
            begin
                // Unused codes leave all state alone.
            end
        endcase

        res_now.head_home = head_home_next;
    end

    assign mem_re = accept && use_mem;
    assign mem_we = accept && store_byte;

    // Stage A result with the data byte from the memory filled in.
    always_comb
    begin
        a_res_final = a_res_reg;
        if (a_use_mem_reg)
        begin
            a_res_final.read_byte = rd_data_reg;
        end
    end

    // Disk memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            disk_mem[mem_addr] <= c.write_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= disk_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_track_reg[0]  <= '0;
            head_track_reg[1]  <= '0;
            head_sector_reg[0] <= '0;
            head_sector_reg[1] <= '0;
            preamble_count_reg <= '0;
            sync_phase_reg     <= PH_SYNC1;
            byte_index_reg     <= '0;
            reading_reg        <= 1'b0;
            writing_reg        <= 1'b0;
            head_home_reg      <= 1'b0;
            a_valid_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_track_reg     <= head_track_next;
                head_sector_reg    <= head_sector_next;
                preamble_count_reg <= preamble_count_next;
                sync_phase_reg     <= sync_phase_next;
                byte_index_reg     <= byte_index_next;
                reading_reg        <= reading_next;
                writing_reg        <= writing_next;
                head_home_reg      <= head_home_next;
            end

            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_res_reg     <= res_now;
            a_use_mem_reg <= use_mem;
        end
        if (a_adv)
        begin
            out_res_reg <= a_res_final;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_res_reg;

    // A read and a write never share one memory access.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    // Only one transfer direction is active at a time.
    assert property (@(posedge clk) disable iff (!rst_n) !(reading_reg && writing_reg))
        else $error("read and write transfer both active");

    // Heads stay within the disk geometry.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_track_reg[0] <= TRACK_MAX && head_track_reg[1] <= TRACK_MAX &&
        head_sector_reg[0] <= SECTOR_MAX && head_sector_reg[1] <= SECTOR_MAX)
        else $error("head position outside the disk geometry");

    // Memory data waiting in stage A is not overwritten while that stage is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_adv) |=> $stable(rd_data_reg))
        else $error("memory read data changed under a stalled result");

endmodule

`default_nettype wire

/* dv/floppy_sector_controller_tb.sv */
// Self-checking testbench of the floppy sector controller: directed table, then random runs.
`timescale 1ns / 1ps

module floppy_sector_controller_tb import fsc_pkg::*;;

    // Geometry of the controller under test. The predictor below uses the same values.
    localparam int TRACKS      = 35;
    localparam int SECTORS     = 10;
    localparam int BLOCK_BYTES = 512;

    // Operation codes the package leaves unnamed. The controller must treat them as no-ops.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Number of transactions in the random part that actually do something.
    localparam int RANDOM_ITEMS   = 1800;
    // Length of the one long receiver hold-off that backs the controller up.
    localparam int HOLDOFF_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;

    fsc_cmd_if cmd_ch ();
    fsc_res_if res_ch ();

    floppy_sector_controller #(
        .TRACKS      (TRACKS),
        .SECTORS     (SECTORS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Predicted controller state. It mirrors the architectural state of the block: head
    // position per drive, the transfer mode and phase, and the bytes written so far. The
    // disk image is sparse, so a missing key marks a byte that was never written.
    // ------------------------------------------------------------------------------------
    logic [TRACK_W-1:0]  trk [2];
    logic [SECTOR_W-1:0] sec [2];
    int unsigned         pre_cnt;
    phase_t              phase;
    int unsigned         idx;
    bit                  rd_mode;
    bit                  wr_mode;
    bit                  tz_flag;
    logic [7:0]          disk_img [int unsigned];
    bit                  last_ignored;

    // Expected results in the order the controller must deliver them.
    res_t awaited[$];

    int unsigned mismatches = 0;
    int unsigned work_items = 0;
    int unsigned burst_left = 0;
    bit          bulk_phase = 1'b0;
    bit          holdoff_done = 1'b0;

    // Random single bit and random byte.
    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Byte address of the current transfer position on drive d, side s.
    function automatic int unsigned disk_addr(input bit d, input bit s);
        int unsigned a;
        a = (32'(d) * 2 + 32'(s)) * TRACKS + 32'(trk[d]);
        a = (a * SECTOR_SLOTS + 32'(sec[d])) * BLOCK_BYTES;
        return a + idx;
    endfunction

    // Header byte that identifies the sector under the head of drive d.
    function automatic logic [7:0] sector_id(input bit d);
        return {trk[d][3:0], sec[d]};
    endfunction

    // True when a read byte on (d, s) would fetch a data byte that was never written.
    // The stored value there is undefined, so such a read is never issued.
    function automatic bit reads_unwritten(input bit d, input bit s);
        return rd_mode && phase == PH_DATA && idx < BLOCK_BYTES &&
               !disk_img.exists(disk_addr(d, s));
    endfunction

    function automatic void drop_transfer();
        pre_cnt = 0;
        phase   = PH_SYNC1;
        idx     = 0;
        rd_mode = 1'b0;
        wr_mode = 1'b0;
    endfunction

    // Applies one command to the predicted state and returns the result it must produce.
    function automatic res_t controller_step(input cmd_t c);
        res_t r;
        bit   d;
        bit   s;
        r = '0;
        d = c.drive_select;
        s = c.side_select;
        last_ignored = 1'b0;
        case (c.operation)
            OP_STEP:
            begin
                // The head saturates at both ends of the disk.
                if (c.step_outward)
                begin
                    if (trk[d] < TRACKS - 1)
                        trk[d] = trk[d] + 1'b1;
                end
                else if (trk[d] > 0)
                    trk[d] = trk[d] - 1'b1;
                tz_flag = (trk[d] == 0);
            end
            OP_SECTOR:
            begin
                r.sector_number = sec[d];
                sec[d] = SECTOR_W'((32'(sec[d]) + 1) % SECTORS);
                drop_transfer();
            end
            OP_START_READ:
            begin
                drop_transfer();
                rd_mode = 1'b1;
                phase = PH_SYNC2;
                r.read_byte = SYNC1_BYTE;
            end
            OP_START_WRITE:
            begin
                drop_transfer();
                wr_mode = 1'b1;
            end
            OP_READ_BYTE:
            begin
                if (!rd_mode)
                    last_ignored = 1'b1;
                else if (phase == PH_SYNC2)
                begin
                    phase = PH_DATA;
                    r.read_byte = sector_id(d);
                end
                else if (idx >= BLOCK_BYTES)
                begin
                    drop_transfer();
                    r.block_done = 1'b1;
                end
                else
                begin
                    r.read_byte = disk_img.exists(disk_addr(d, s)) ?
                                  disk_img[disk_addr(d, s)] : 8'h00;
                    idx++;
                end
            end
            OP_WRITE_BYTE:
            begin
                // A bad header byte is flagged, but the transfer still moves on.
                if (!wr_mode)
                    last_ignored = 1'b1;
                else if (pre_cnt < PREAMBLE_LEN)
                begin
                    if (c.write_byte != 8'h00)
                        r.write_status = WST_PREAMBLE;
                    pre_cnt++;
                end
                else if (phase == PH_SYNC1)
                begin
                    if (c.write_byte != SYNC1_BYTE)
                        r.write_status = WST_SYNC1;
                    phase = PH_SYNC2;
                end
                else if (phase == PH_SYNC2)
                begin
                    if (c.write_byte != sector_id(d))
                        r.write_status = WST_SYNC2;
                    phase = PH_DATA;
                end
                else if (idx >= BLOCK_BYTES)
                begin
                    drop_transfer();
                    r.block_done = 1'b1;
                end
                else
                begin
                    disk_img[disk_addr(d, s)] = c.write_byte;
                    idx++;
                end
            end
            default:
                last_ignored = 1'b1;
        endcase
        r.head_home = tz_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Command side. Inputs change on the falling edge; acceptance is seen on the rising
    // edge. The sender runs in bursts of random length separated by random gaps. The
    // expectation is queued at the accepting edge, from the state left by all earlier
    // commands, so the next command is always generated against an up-to-date model.
    // ------------------------------------------------------------------------------------
    task automatic issue_cmd(input cmd_t c, input bit typed, input res_t want);
        int unsigned gap;
        res_t        predicted;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 60);
        end
        @(negedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        burst_left--;
        predicted = controller_step(c);
        if (!last_ignored)
            work_items++;
        // Rows of the opening table carry a hand-written expectation instead.
        awaited.push_back(typed ? want : predicted);
    endtask

    // Builds a command from its fields and sends it. A read that would touch a never
    // written byte is turned into a spare opcode, which the controller must ignore.
    task automatic offer(input logic [2:0] op, input bit d, input bit s, input bit o,
                         input logic [7:0] b);
        cmd_t c;
        if (op == OP_READ_BYTE && reads_unwritten(d, s))
            op = OP_SPARE_7;
        c.operation    = op;
        c.drive_select = d;
        c.side_select  = s;
        c.step_outward = o;
        c.write_byte   = b;
        issue_cmd(c, 1'b0, '0);
    endtask

    // One write transaction sequence: preamble, both sync bytes and a run of data. Header
    // bytes are mostly right and sometimes wrong. With full set, the whole block plus the
    // trailing slot is written, which must end the transfer with block_done.
    task automatic write_run(input bit d, input bit s, input bit full);
        int unsigned n;
        int unsigned k;
        logic [7:0]  b;
        bit          dd;
        bit          ss;
        offer(OP_START_WRITE, d, s, coin(), any_byte());
        for (k = 0; k < PREAMBLE_LEN; k++)
        begin
            b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            offer(OP_WRITE_BYTE, coin(), coin(), coin(), b);
        end
        b = ($urandom_range(0, 7) == 0) ? any_byte() : SYNC1_BYTE;
        offer(OP_WRITE_BYTE, d, s, coin(), b);
        b = ($urandom_range(0, 7) == 0) ? any_byte() : sector_id(d);
        offer(OP_WRITE_BYTE, d, s, coin(), b);
        n = full ? BLOCK_BYTES + 1 : $urandom_range(1, 48);
        for (k = 0; k < n; k++)
        begin
            // Now and then the drive or side changes in the middle of the data.
            dd = ($urandom_range(0, 19) == 0) ? !d : d;
            ss = ($urandom_range(0, 19) == 0) ? !s : s;
            offer(OP_WRITE_BYTE, dd, ss, coin(), any_byte());
        end
    endtask

    // One read sequence: start, sector header, then data for as long as it was written or until a random stop.
    // Reaching the end of a full block takes the trailing slot, which ends the transfer.
    task automatic read_run(input bit d, input bit s);
        bit dd;
        bit ss;
        offer(OP_START_READ, coin(), coin(), coin(), any_byte());
        offer(OP_READ_BYTE, d, s, coin(), any_byte());
        while (rd_mode)
        begin
            dd = d;
            ss = s;
            if ($urandom_range(0, 15) == 0)
            begin
                dd = coin();
                ss = coin();
                if (reads_unwritten(dd, ss))
                begin
                    dd = d;
                    ss = s;
                end
            end
            if (reads_unwritten(dd, ss) || $urandom_range(0, 79) == 0)
                break;
            offer(OP_READ_BYTE, dd, ss, coin(), any_byte());
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Opening table. Each row is one command; rows with a typed expectation are checked
    // against that value, the others against the predictor. The rows walk reset state,
    // head saturation at track zero, idle accesses, the spare opcodes, the header bytes
    // of a read, a bad preamble byte and a sector pulse that cuts a write short.
    // ------------------------------------------------------------------------------------
    typedef struct packed {
        logic [2:0] op;
        logic       d;
        logic       s;
        logic       o;
        logic [7:0] b;
        logic       typed;
        res_t       want;
    } script_row_t;

    localparam script_row_t OPENING [23] = '{
        // Right after reset the track-zero flag is still low.
        '{OP_SECTOR,      1'b0, 1'b0, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        // Stepping inward at track zero saturates and raises the flag.
        '{OP_STEP,        1'b0, 1'b0, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_READ_BYTE,   1'b0, 1'b0, 1'b1, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_WRITE_BYTE,  1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_SPARE_6,     1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_SPARE_7,     1'b0, 1'b1, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_START_READ,  1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
          '{SYNC1_BYTE, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_READ_BYTE,   1'b0, 1'b1, 1'b0, 8'h00, 1'b0, '0},
        '{OP_SECTOR,      1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        // The pulse ended the read, so this is an idle access again.
        '{OP_READ_BYTE,   1'b0, 1'b0, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}},
        '{OP_STEP,        1'b1, 1'b0, 1'b1, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_STEP,        1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_STEP,        1'b1, 1'b0, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_START_WRITE, 1'b1, 1'b0, 1'b0, 8'hFF, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_WRITE_BYTE,  1'b1, 1'b0, 1'b0, 8'hFF, 1'b1,
          '{8'h00, 4'd0, 1'b0, WST_PREAMBLE, 1'b0}},
        '{OP_WRITE_BYTE,  1'b1, 1'b1, 1'b1, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_WRITE_BYTE,  1'b0, 1'b0, 1'b0, 8'h01, 1'b1,
          '{8'h00, 4'd0, 1'b0, WST_PREAMBLE, 1'b0}},
        '{OP_START_READ,  1'b1, 1'b1, 1'b1, 8'h00, 1'b1,
          '{SYNC1_BYTE, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_READ_BYTE,   1'b1, 1'b1, 1'b0, 8'hFF, 1'b0, '0},
        '{OP_START_WRITE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_SECTOR,      1'b0, 1'b1, 1'b1, 8'h00, 1'b0, '0},
        // The pulse above ended the write, so this byte is ignored.
        '{OP_WRITE_BYTE,  1'b0, 1'b1, 1'b1, 8'h80, 1'b1, '{8'h00, 4'd0, 1'b0, WST_OK, 1'b0}},
        '{OP_STEP,        1'b1, 1'b0, 1'b0, 8'h00, 1'b1, '{8'h00, 4'd0, 1'b1, WST_OK, 1'b0}}
    };

    // ------------------------------------------------------------------------------------
    // Result side: the receiver stalls in stretches of different character, and once,
    // after the random part has begun, holds off for a long stretch so that both internal
    // result slots fill and the command input has to stall.
    // ------------------------------------------------------------------------------------
    initial
    begin : result_pacing
        int unsigned stretch;
        int unsigned mode;
        int unsigned i;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (bulk_phase && !holdoff_done)
            begin
                for (i = 0; i < HOLDOFF_CYCLES; i++)
                begin
                    @(negedge clk);
                    res_ch.ready <= 1'b0;
                end
                holdoff_done = 1'b1;
            end
            stretch = $urandom_range(10, 120);
            mode = $urandom_range(0, 3);
            for (i = 0; i < stretch; i++)
            begin
                @(negedge clk);
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= coin();
                    2: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Every accepted result is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.payload;
            if (awaited.size() == 0)
                note_mismatch("result with nothing pending", 32'(got), 32'd0);
            else
            begin
                want = awaited.pop_front();
                if (got.read_byte !== want.read_byte)
                    note_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
                if (got.sector_number !== want.sector_number)
                    note_mismatch("sector_number", 32'(got.sector_number),
                                  32'(want.sector_number));
                if (got.head_home !== want.head_home)
                    note_mismatch("head_home", 32'(got.head_home), 32'(want.head_home));
                if (got.write_status !== want.write_status)
                    note_mismatch("write_status", 32'(got.write_status),
                                  32'(want.write_status));
                if (got.block_done !== want.block_done)
                    note_mismatch("block_done", 32'(got.block_done), 32'(want.block_done));
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence: reset, opening table, then random traffic. The random part is mostly
    // well-formed transfers (write followed by a read back of the same sector, which is
    // what reaches the data phase and the end of a block) mixed with head moves, sector
    // pulses and free-form noise. The first write covers a whole block.
    // ------------------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned i;
        int unsigned pick;
        int unsigned n;
        bit          d;
        bit          s;
        bit          o;
        bit          full;
        bit          full_seen;
        cmd_t        c;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        trk[0] = '0;
        trk[1] = '0;
        sec[0] = '0;
        sec[1] = '0;
        tz_flag = 1'b0;
        drop_transfer();
        full_seen = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(OPENING); i++)
        begin
            c.operation    = OPENING[i].op;
            c.drive_select = OPENING[i].d;
            c.side_select  = OPENING[i].s;
            c.step_outward = OPENING[i].o;
            c.write_byte   = OPENING[i].b;
            issue_cmd(c, OPENING[i].typed, OPENING[i].want);
        end

        bulk_phase = 1'b1;
        work_items = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            d = coin();
            s = coin();
            if (pick < 30)
            begin
                full = !full_seen || $urandom_range(0, 11) == 0;
                full_seen = 1'b1;
                write_run(d, s, full);
                read_run(d, s);
            end
            else if (pick < 45)
                read_run(d, s);
            else if (pick < 58)
                write_run(d, s, 1'b0);
            else if (pick < 73)
            begin
                // Mostly short seeks; sometimes a long one that runs into either end.
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 3);
                o = coin();
                repeat (n)
                    offer(OP_STEP, d, coin(), o, any_byte());
            end
            else if (pick < 88)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    offer(OP_SECTOR, coin(), coin(), coin(), any_byte());
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    offer(3'($urandom_range(0, 7)), coin(), coin(), coin(), any_byte());
            end
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        // Drain, then keep watching the pipeline for any stray result before finishing.
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("floppy_sector_controller: match");
        else
            $display("floppy_sector_controller: mismatch");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin : watchdog
        #1_000_000;
        $display("floppy_sector_controller: mismatch");
        $finish;
    end

endmodule

/* floppy_sector_controller.f */
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_cmd_if.sv
hw/rtl/fsc_res_if.sv
hw/rtl/floppy_sector_controller.sv
dv/floppy_sector_controller_tb.sv
